### design/assert_macros.svh
// Assertion helpers, included by the lookup core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define KSHL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define KSHL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### design/kshl_pkg.sv
package kshl_pkg;

  localparam int TableDepthDefault = 32;
  localparam int PrimCount         = 5;
  localparam int KeyW              = 32;
  localparam int IdW               = 3;

  // input command codes
  localparam logic [1:0] CMD_LOOKUP  = 2'd0;
  localparam logic [1:0] CMD_DEFINE  = 2'd1;
  localparam logic [1:0] CMD_RESTORE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_RESTORE
  } cell_op_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
    logic       last;
    logic [2:0] def_op;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  op_found;
    logic [31:0] word_hash;
  } out_item_t;

  // broadcast from the control to every cell
  typedef struct packed {
    cell_op_e         op;
    logic [KeyW-1:0]  key;
    logic [IdW-1:0]   id;
  } cell_ctrl_t;

  // what a cell hands to its right-hand neighbour
  typedef struct packed {
    logic            valid;
    logic            gt;
    logic            eq;
    logic [KeyW-1:0] key;
    logic [IdW-1:0]  id;
  } cell_link_t;

  // primitive keyword sums: ANEXAR, ORDENAR, EXTRAER, MOSTRAR, INSERTAR
  function automatic logic [KeyW-1:0] prim_key(input int idx);
    logic [KeyW-1:0] k;
    k = '0;
    unique case (idx)
      0:       k = 32'd447;
      1:       k = 32'd523;
      2:       k = 32'd539;
      3:       k = 32'd552;
      4:       k = 32'd616;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [IdW-1:0] prim_id(input int idx);
    logic [IdW-1:0] v;
    v = '0;
    unique case (idx)
      0:       v = 3'd2;
      1:       v = 3'd3;
      2:       v = 3'd4;
      3:       v = 3'd1;
      4:       v = 3'd0;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

### design/kshl_in_if.sv
interface kshl_in_if;
  import kshl_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/kshl_out_if.sv
interface kshl_out_if;
  import kshl_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/kshl_hash.sv
module kshl_hash import kshl_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            clear_i,
  input  logic [7:0]      ch_i,
  output logic [KeyW-1:0] sum_o
);

  logic [KeyW-1:0] word_sum_q, word_sum_d;

  assign sum_o = word_sum_q + {{(KeyW-8){1'b0}}, fold_upper(ch_i)};

  // clear wins: it marks a word end or a table restore
  always_comb begin
    word_sum_d = word_sum_q;
    if (clear_i) begin
      word_sum_d = '0;
    end else if (step_i) begin
      word_sum_d = sum_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_sum_q <= '0;
    end else begin
      word_sum_q <= word_sum_d;
    end
  end

endmodule

### design/kshl_cell.sv
module kshl_cell import kshl_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cell_ctrl_t     ctrl_i,
  input  cell_link_t     prev_i,
  output cell_link_t     next_o,
  output logic           hit_o,
  output logic [IdW-1:0] hit_id_o
);

  localparam logic [KeyW-1:0] ResetKey   = prim_key(CELL_IDX);
  localparam logic [IdW-1:0]  ResetId    = prim_id(CELL_IDX);
  localparam logic            ResetValid = (CELL_IDX < PrimCount);

  logic            valid_q, valid_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [IdW-1:0]  id_q, id_d;
  logic            gt, eq;

  assign gt = valid_q && (key_q > ctrl_i.key);
  assign eq = valid_q && (key_q == ctrl_i.key);

  assign next_o = '{valid: valid_q, gt: gt, eq: eq, key: key_q, id: id_q};

  // equal keys sit together, so only the leftmost equal cell reports
  assign hit_o    = eq && !prev_i.eq;
  assign hit_id_o = hit_o ? id_q : '0;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    id_d    = id_q;
    unique case (ctrl_i.op)
      CELL_RESTORE: begin
        valid_d = ResetValid;
        key_d   = ResetKey;
        id_d    = ResetId;
      end
      CELL_INSERT: begin
        if (prev_i.gt) begin
          valid_d = 1'b1;
          key_d   = prev_i.key;
          id_d    = prev_i.id;
        end else if (gt || (!valid_q && prev_i.valid)) begin
          valid_d = 1'b1;
          key_d   = ctrl_i.key;
          id_d    = ctrl_i.id;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= ResetValid;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= ResetKey;
      id_q  <= ResetId;
    end else begin
      key_q <= key_d;
      id_q  <= id_d;
    end
  end

endmodule

### design/keyword_sum_hash_sorted_lookup_core.sv
// Channel | Dir | Payload                         | Handshake
// in_i    | in  | cmd, ch, last, def_op           | valid/ready
// out_o   | out | status, op_found, word_hash     | valid/ready
//
// One item a cycle: every cell compares its key with the word sum in the
// same cycle, so a lookup or an insert finishes in the cycle the item is taken.
// Results leave through a single output register, valid in the cycle after the item is taken.
// in_i.ready drops only while a result waits in that register with out_o.ready low.
// Reset is asynchronous and loads the five primitive keywords straight away.
`include "assert_macros.svh"

module keyword_sum_hash_sorted_lookup_core import kshl_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  kshl_in_if.sink    in_i,
  kshl_out_if.source out_o
);

  logic            accept;
  logic            is_char, is_restore, is_define;
  logic            word_end, table_full, do_insert;
  logic [KeyW-1:0] sum;

  cell_ctrl_t       ctrl;
  cell_link_t       link [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] hit;
  logic [IdW-1:0]   hit_id [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_vec;

  logic             any_hit;
  logic [IdW-1:0]   found_id;

  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;
  out_item_t result;
  logic      res_valid;

  // take an item whenever the output slot is free or emptying
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    is_char    = 1'b0;
    is_restore = 1'b0;
    is_define  = 1'b0;
    unique case (in_i.data.cmd)
      CMD_LOOKUP:  is_char = 1'b1;
      CMD_DEFINE: begin
        is_char   = 1'b1;
        is_define = 1'b1;
      end
      CMD_RESTORE: is_restore = 1'b1;
      default: begin
        // unused code: drop the item
      end
    endcase
  end

  assign word_end   = accept && is_char && in_i.data.last;
  assign table_full = link[TABLE_DEPTH].valid;
  assign do_insert  = word_end && is_define && !table_full;

  // running word sum
  kshl_hash u_hash (
    .clk_i,
    .rst_ni,
    .step_i  (accept && is_char),
    .clear_i (word_end || (accept && is_restore)),
    .ch_i    (in_i.data.ch),
    .sum_o   (sum)
  );

  // broadcast to the cell row
  always_comb begin
    ctrl.key = sum;
    ctrl.id  = in_i.data.def_op;
    if (accept && is_restore) begin
      ctrl.op = CELL_RESTORE;
    end else if (do_insert) begin
      ctrl.op = CELL_INSERT;
    end else begin
      ctrl.op = CELL_HOLD;
    end
  end

  // left edge of the row: acts as a filled slot holding a small key
  assign link[0] = '{valid: 1'b1, gt: 1'b0, eq: 1'b0, key: '0, id: '0};

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    kshl_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .ctrl_i   (ctrl),
      .prev_i   (link[i]),
      .next_o   (link[i+1]),
      .hit_o    (hit[i]),
      .hit_id_o (hit_id[i])
    );
    assign valid_vec[i] = link[i+1].valid;
  end

  // at most one cell hits, so OR the ids together
  always_comb begin
    found_id = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      found_id = found_id | hit_id[i];
    end
  end
  assign any_hit = |hit;

  // form the result of this item
  always_comb begin
    res_valid = word_end || (accept && is_restore);
    result    = '{status: ST_OK, op_found: '0, word_hash: sum};
    if (is_restore) begin
      result.word_hash = '0;
    end else if (is_define) begin
      if (table_full) begin
        result.status = ST_FULL;
      end
    end else if (any_hit) begin
      result.op_found = found_id;
    end else begin
      result.status = ST_MISS;
    end
  end

  // output register: load a new result, or drop the old one once taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_i.ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_data_d = result;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // filled cells always form an unbroken run from the left
  `KSHL_ASSERT_ALWAYS(a_valid_prefix, (valid_vec & ~{valid_vec[TABLE_DEPTH-2:0], 1'b1}) == '0, "cell row has a gap")
  // a restore leaves exactly the primitive entries
  `KSHL_ASSERT(a_restore_count, (accept && is_restore) |=> ($countones(valid_vec) == PrimCount), "restore count wrong")
  // an insert adds exactly one entry
  `KSHL_ASSERT(a_insert_grows, do_insert |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1), "insert count wrong")

endmodule
